@@ src/fpfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;
  localparam int AMT_BITS       = 16;
  localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
  localparam int CNT_BITS       = 5;
  localparam int POL_BITS       = 2;

  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_PARTITIONS);

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_RSVD   = 2'd3
  } status_t;

  localparam logic [POL_BITS-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_BITS-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_BITS-1:0] POL_WORST = 2'd2;

  localparam logic CFG_FIT_POLICY     = 1'b0;
  localparam logic CFG_NUM_PARTITIONS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_BITS-1:0]  addr;
    logic [SIZE_BITS-1:0] data;
  } size_wr_t;

endpackage

@@ src/fpfa_size_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_size_table
// Partition size memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpfa_size_table import fpfa_pkg::*; (
  input  logic                 clk,
  input  size_wr_t             wr,
  input  logic [IDX_BITS-1:0]  rd_addr,
  output logic [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0] mem [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/fixed_partition_fit_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Fixed partition allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Each input item gives one result. A load or clear item goes from idle
// through the response state back to idle before the next input transfer. A
// request walks the active partitions one per cycle through a single size
// comparator fed from the registered read port of the size memory, in the
// scan and last states before the response state. Results sit in an output
// register, so a waiting result holds only the final response step.
// Configuration writes are taken only while the block is idle.
module fixed_partition_fit_allocator_core import fpfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [IDX_BITS-1:0]  in_slot_index,
  input  logic [AMT_BITS-1:0]  in_amount,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_granted,
  output logic [IDX_BITS-1:0]  out_granted_slot,
  output logic [1:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [CNT_BITS-1:0]  cfg_data
);

  state_t state_r, state_nxt;

  logic [POL_BITS-1:0]       fit_policy_r;
  logic [CNT_BITS-1:0]       num_part_r;
  logic [MAX_PARTITIONS-1:0] occupied_r;
  logic [AMT_BITS-1:0]       amount_r;
  logic [IDX_BITS-1:0]       scan_idx_r;
  logic [IDX_BITS-1:0]       cmp_idx_r;
  logic                      cmp_vld_r;
  logic                      pick_vld_r, pick_vld_nxt;
  logic [IDX_BITS-1:0]       pick_idx_r, pick_idx_nxt;
  logic [SIZE_BITS-1:0]      pick_size_r, pick_size_nxt;
  logic                      res_granted_r;
  logic [IDX_BITS-1:0]       res_slot_r;
  status_t                   res_status_r;
  logic                      out_valid_r;
  logic                      out_granted_r;
  logic [IDX_BITS-1:0]       out_slot_r;
  status_t                   out_status_r;

  logic [CNT_BITS-1:0]  cnt_eff;
  logic [IDX_BITS-1:0]  last_idx;
  logic                 in_xfer;
  logic                 out_load;
  logic                 load_ok;
  logic                 issue;
  logic                 fit;
  logic                 better;
  logic [SIZE_BITS-1:0] rd_data;
  size_wr_t             size_wr;
  mode_t                mode;

  assign mode     = mode_t'(in_mode);
  assign cnt_eff  = (num_part_r > CNT_MAX) ? CNT_MAX : num_part_r;
  assign last_idx = IDX_BITS'(cnt_eff - CNT_BITS'(1));
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_ready);
  assign load_ok  = {1'b0, in_slot_index} < cnt_eff;
  assign issue    = (state_r == ST_SCAN);

  assign size_wr.en   = in_xfer && (mode == MODE_LOAD) && load_ok;
  assign size_wr.addr = in_slot_index;
  assign size_wr.data = SIZE_BITS'(in_amount);

  fpfa_size_table u_size_table (
    .clk     (clk),
    .wr      (size_wr),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  // candidate compare
  always_comb begin
    fit    = cmp_vld_r && !occupied_r[cmp_idx_r] && (rd_data >= amount_r);
    better = !pick_vld_r ||
             ((fit_policy_r == POL_BEST)  && (rd_data < pick_size_r)) ||
             ((fit_policy_r == POL_WORST) && (rd_data > pick_size_r));
    pick_vld_nxt  = pick_vld_r;
    pick_idx_nxt  = pick_idx_r;
    pick_size_nxt = pick_size_r;
    if (fit && better) begin
      pick_vld_nxt  = 1'b1;
      pick_idx_nxt  = cmp_idx_r;
      pick_size_nxt = rd_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((mode == MODE_REQUEST) && (cnt_eff != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == last_idx) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fit_policy_r <= POL_FIRST;
      num_part_r   <= CNT_MAX;
      occupied_r   <= '0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= issue;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIT_POLICY:     fit_policy_r <= cfg_data[POL_BITS-1:0];
          CFG_NUM_PARTITIONS: num_part_r   <= cfg_data;
          default: ;
        endcase
      end

      if (in_xfer && (mode == MODE_CLEAR)) begin
        occupied_r <= '0;
      end else if ((state_r == ST_LAST) && pick_vld_nxt) begin
        occupied_r[pick_idx_nxt] <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= scan_idx_r;
    pick_vld_r  <= in_xfer ? 1'b0 : pick_vld_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_size_r <= pick_size_nxt;

    if (in_xfer) begin
      amount_r      <= in_amount;
      scan_idx_r    <= '0;
      res_granted_r <= 1'b0;
      res_slot_r    <= '0;
      priority case (1'b1)
        (mode == MODE_LOAD) && !load_ok: res_status_r <= STAT_RANGE;
        (mode == MODE_REQUEST):          res_status_r <= STAT_NO_FIT;
        default:                         res_status_r <= STAT_DONE;
      endcase
    end else if (issue && (scan_idx_r != last_idx)) begin
      scan_idx_r <= scan_idx_r + IDX_BITS'(1);
    end

    if (state_r == ST_LAST) begin
      res_granted_r <= pick_vld_nxt;
      res_slot_r    <= pick_vld_nxt ? pick_idx_nxt : '0;
      res_status_r  <= pick_vld_nxt ? STAT_DONE : STAT_NO_FIT;
    end

    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_slot_r    <= res_slot_r;
      out_status_r  <= res_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({1'b0, scan_idx_r} < cnt_eff))
    else $error("scan index beyond active count");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> ((state_r == ST_SCAN) || (state_r == ST_LAST)))
    else $error("compare outside scan");

  a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESP) && res_granted_r) |-> occupied_r[res_slot_r])
    else $error("granted partition not marked occupied");

  a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r) |-> (out_status_r == STAT_DONE))
    else $error("grant with failure status");

endmodule

@@ sim/tb_fixed_partition_fit_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_partition_fit_allocator_core
// Self-checking bench for the fixed partition fit allocator. A directed table
// loads every partition, then covers each placement rule, the range and
// no-fit errors, the ignored mode, a zero count and a count above the table.
// Random phases follow, each with a fresh policy and partition count. Every
// transfer is predicted by an in-bench allocation model and each result is
// compared field by field. Input bursts and output stalls vary throughout.
// ----------------------------------------------------------------------------
module tb_fixed_partition_fit_allocator_core;
  import fpfa_pkg::*;

  localparam logic [POL_BITS-1:0] POL_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 860;

  typedef struct packed {
    logic                granted;
    logic [IDX_BITS-1:0] slot;
    status_t             status;
  } alloc_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    mode_t                mode;
    logic [IDX_BITS-1:0]  slot;
    logic [AMT_BITS-1:0]  amount;
    logic                 reg_idx;
    bit                   typed;
    alloc_result_t        res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_mode = MODE_LOAD;
  logic [IDX_BITS-1:0]  in_slot_index = '0;
  logic [AMT_BITS-1:0]  in_amount = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_granted;
  logic [IDX_BITS-1:0]  out_granted_slot;
  logic [1:0]           out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = CFG_FIT_POLICY;
  logic [CNT_BITS-1:0]  cfg_data = '0;

  fixed_partition_fit_allocator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_slot_index    (in_slot_index),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted      (out_granted),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  // allocator state mirror
  logic [SIZE_BITS-1:0] part_size_m [MAX_PARTITIONS];
  bit                   occupied_m  [MAX_PARTITIONS];
  logic [POL_BITS-1:0]  fit_pol;
  logic [CNT_BITS-1:0]  part_cnt;

  alloc_result_t pending_results [$];
  stim_row_t     stim_rows [$];
  int            mismatch_cnt = 0;
  int            burst_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic predict_alloc(input mode_t m, input logic [IDX_BITS-1:0] s,
                               input logic [AMT_BITS-1:0] a, output alloc_result_t r);
    int eff;
    int pick;
    eff = (part_cnt > CNT_MAX) ? MAX_PARTITIONS : int'(part_cnt);
    pick = -1;
    r = '{granted: 1'b0, slot: '0, status: STAT_DONE};
    case (m)
      MODE_LOAD: begin
        if (int'(s) < eff) part_size_m[s] = a[SIZE_BITS-1:0];
        else r.status = STAT_RANGE;
      end
      MODE_REQUEST: begin
        for (int k = 0; k < eff; k++) begin
          if (!occupied_m[k] && part_size_m[k] >= a) begin
            if (pick < 0) pick = k;
            else if (fit_pol == POL_BEST && part_size_m[k] < part_size_m[pick]) pick = k;
            else if (fit_pol == POL_WORST && part_size_m[k] > part_size_m[pick]) pick = k;
          end
        end
        if (pick >= 0) begin
          occupied_m[pick] = 1'b1;
          r.granted = 1'b1;
          r.slot = IDX_BITS'(pick);
        end else begin
          r.status = STAT_NO_FIT;
        end
      end
      MODE_CLEAR: begin
        for (int k = 0; k < MAX_PARTITIONS; k++) occupied_m[k] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic issue_item(input mode_t m, input logic [IDX_BITS-1:0] s,
                            input logic [AMT_BITS-1:0] a, input bit typed,
                            input alloc_result_t typed_res);
    alloc_result_t pred;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
                   $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_slot_index <= s;
    in_amount     <= a;
    do @(posedge clk); while (!in_ready);
    predict_alloc(m, s, a, pred);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [CNT_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIT_POLICY) fit_pol = val[POL_BITS-1:0];
    else part_cnt = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_item(input mode_t m, input logic [IDX_BITS-1:0] s,
                          input logic [AMT_BITS-1:0] a);
    stim_rows.push_back('{ROW_ITEM, m, s, a, 1'b0, 1'b0, '0});
  endtask

  task automatic add_typed(input mode_t m, input logic [IDX_BITS-1:0] s,
                           input logic [AMT_BITS-1:0] a, input logic g,
                           input logic [IDX_BITS-1:0] gs, input status_t st);
    stim_rows.push_back('{ROW_ITEM, m, s, a, 1'b0, 1'b1, '{g, gs, st}});
  endtask

  task automatic add_cfg(input logic idx, input logic [CNT_BITS-1:0] val);
    stim_rows.push_back('{ROW_CFG, MODE_NONE, '0, AMT_BITS'(val), idx, 1'b0, '0});
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_granted !== exp_r.granted)
          report_mismatch($sformatf("granted %0b, expected %0b", out_granted, exp_r.granted));
        if (out_granted_slot !== exp_r.slot)
          report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                    out_granted_slot, exp_r.slot));
        if (out_status !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_r.status));
      end
    end
  end

  // receiver stall pattern, reshuffled whenever stall_cyc[5:0] is zero
  int unsigned stall_cyc = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc[5:0] == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_cyc[2:0] != 3'd0);
    endcase
  end

  initial begin
    int rand_items;
    int phase_len;
    int r;
    int sz;
    int d;
    mode_t m;
    logic [IDX_BITS-1:0] s;
    logic [AMT_BITS-1:0] a;

    for (int k = 0; k < MAX_PARTITIONS; k++) begin
      part_size_m[k] = '0;
      occupied_m[k] = 1'b0;
    end
    fit_pol = POL_FIRST;
    part_cnt = CNT_MAX;

    // load every partition at reset settings
    add_typed(MODE_LOAD, 4'd0, 16'd100, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd1, 16'd50, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd2, 16'hFFFF, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd3, 16'd0, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd4, 16'd200, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd5, 16'd50, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd6, 16'd300, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd7, 16'd10, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd8, 16'hFFFF, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd9, 16'd1, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd10, 16'd1000, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd11, 16'd40000, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd12, 16'd7, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd13, 16'd50, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd14, 16'h8000, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_LOAD, 4'd15, 16'hFFFE, 1'b0, 4'd0, STAT_DONE);
    add_item(MODE_REQUEST, 4'd0, 16'd60);
    add_item(MODE_REQUEST, 4'd15, 16'hFFFF);
    add_item(MODE_REQUEST, 4'd0, 16'd0);
    add_item(MODE_REQUEST, 4'd0, 16'hFFFF);
    add_typed(MODE_REQUEST, 4'd0, 16'hFFFF, 1'b0, 4'd0, STAT_NO_FIT);
    add_typed(MODE_NONE, 4'd15, 16'hFFFF, 1'b0, 4'd0, STAT_DONE);
    add_typed(MODE_CLEAR, 4'd9, 16'h1234, 1'b0, 4'd0, STAT_DONE);
    add_cfg(CFG_NUM_PARTITIONS, 5'd4);
    add_typed(MODE_LOAD, 4'd4, 16'd5, 1'b0, 4'd0, STAT_RANGE);
    add_cfg(CFG_FIT_POLICY, POL_BEST);
    add_item(MODE_REQUEST, 4'd0, 16'd50);
    add_cfg(CFG_FIT_POLICY, POL_WORST);
    add_item(MODE_REQUEST, 4'd0, 16'd1);
    add_cfg(CFG_NUM_PARTITIONS, 5'd0);
    add_typed(MODE_REQUEST, 4'd0, 16'd0, 1'b0, 4'd0, STAT_NO_FIT);
    add_typed(MODE_LOAD, 4'd0, 16'd0, 1'b0, 4'd0, STAT_RANGE);
    add_cfg(CFG_NUM_PARTITIONS, 5'd31);
    add_cfg(CFG_FIT_POLICY, POL_UNUSED);
    add_item(MODE_REQUEST, 4'd0, 16'd0);
    add_typed(MODE_CLEAR, 4'd0, 16'd0, 1'b0, 4'd0, STAT_DONE);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].amount[CNT_BITS-1:0]);
      end else begin
        issue_item(stim_rows[i].mode, stim_rows[i].slot, stim_rows[i].amount,
                   stim_rows[i].typed, stim_rows[i].res);
      end
    end

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      settle();
      write_reg(CFG_FIT_POLICY, CNT_BITS'($urandom_range(0, 3)));
      r = $urandom_range(0, 9);
      case (r)
        0: write_reg(CFG_NUM_PARTITIONS, 5'd0);
        1: write_reg(CFG_NUM_PARTITIONS, 5'd1);
        2: write_reg(CFG_NUM_PARTITIONS, CNT_MAX);
        3: write_reg(CFG_NUM_PARTITIONS, CNT_BITS'($urandom_range(17, 31)));
        default: write_reg(CFG_NUM_PARTITIONS, CNT_BITS'($urandom_range(1, 16)));
      endcase
      phase_len = $urandom_range(30, 90);
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom_range(0, 99);
        s = IDX_BITS'($urandom_range(0, MAX_PARTITIONS - 1));
        a = AMT_BITS'($urandom);
        if (r < 30) begin
          m = MODE_LOAD;
          d = $urandom_range(0, 9);
          if (d == 0) a = '0;
          else if (d == 1) a = '1;
        end else if (r < 82) begin
          m = MODE_REQUEST;
          d = $urandom_range(0, 19);
          if (d < 3) begin
            a = '0;
          end else if (d < 5) begin
            a = '1;
          end else if (d < 15) begin
            sz = int'(part_size_m[$urandom_range(0, MAX_PARTITIONS - 1)]);
            d = $urandom_range(0, 2);
            a = AMT_BITS'((sz > d) ? sz - d : 0);
          end
        end else if (r < 92) begin
          m = MODE_CLEAR;
        end else begin
          m = MODE_NONE;
        end
        issue_item(m, s, a, 1'b0, '0);
        rand_items++;
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fpfa_pkg.sv
src/fpfa_size_table.sv
src/fixed_partition_fit_allocator_core.sv
sim/tb_fixed_partition_fit_allocator_core.sv
